@@ rtl/b64dec_pkg.sv @@
// b64dec_pkg: shared types, constants and the character classifier for the base64 decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package b64dec_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned SextW  = 6;
	localparam int unsigned BitsW  = 3;
	localparam int unsigned CountW = 8;

	localparam logic [CountW-1:0] MaxBytesReset = 8'd32;

	localparam logic [SextW-1:0] UpperBase = 6'd0;
	localparam logic [SextW-1:0] LowerBase = 6'd26;
	localparam logic [SextW-1:0] DigitBase = 6'd52;
	localparam logic [SextW-1:0] PlusCode  = 6'd62;
	localparam logic [SextW-1:0] SlashCode = 6'd63;

	localparam logic [CharW-1:0] ChPad   = 8'h3d;
	localparam logic [CharW-1:0] ChLf    = 8'h0a;
	localparam logic [CharW-1:0] ChCr    = 8'h0d;
	localparam logic [CharW-1:0] ChSpace = 8'h20;
	localparam logic [CharW-1:0] ChPlus  = 8'h2b;
	localparam logic [CharW-1:0] ChSlash = 8'h2f;
	localparam logic [CharW-1:0] ChUpA   = 8'h41;
	localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
	localparam logic [CharW-1:0] ChLoA   = 8'h61;
	localparam logic [CharW-1:0] ChLoZ   = 8'h7a;
	localparam logic [CharW-1:0] Ch0     = 8'h30;
	localparam logic [CharW-1:0] Ch9     = 8'h39;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_INVALID  = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		CLS_SEXTET  = 2'd0,
		CLS_SKIP    = 2'd1,
		CLS_INVALID = 2'd2
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t        kind;
		logic [SextW-1:0] value;
	} char_class_t;

	typedef struct packed {
		logic [CharW-1:0]  data_byte;
		logic              byte_valid;
		err_t              error_code;
		logic              done_res;
		logic [CountW-1:0] byte_count;
	} result_t;

	function automatic char_class_t classify(input logic [CharW-1:0] c);
		char_class_t r;
		logic [CharW-1:0] d;
		r.kind  = CLS_SEXTET;
		r.value = '0;
		d       = '0;
		if (c >= ChUpA && c <= ChUpZ) begin
			d       = c - ChUpA;
			r.value = UpperBase + d[SextW-1:0];
		end else if (c >= ChLoA && c <= ChLoZ) begin
			d       = c - ChLoA;
			r.value = LowerBase + d[SextW-1:0];
		end else if (c >= Ch0 && c <= Ch9) begin
			d       = c - Ch0;
			r.value = DigitBase + d[SextW-1:0];
		end else if (c == ChPlus) begin
			r.value = PlusCode;
		end else if (c == ChSlash) begin
			r.value = SlashCode;
		end else if (c == ChPad || c == ChLf || c == ChCr || c == ChSpace) begin
			r.kind = CLS_SKIP;
		end else begin
			r.kind = CLS_INVALID;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/b64dec_class.sv @@
// b64dec_class: maps one ascii character to a sextet, a skip mark or an invalid mark
// depends on b64dec_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64dec_class (
	input  wire logic [b64dec_pkg::CharW-1:0] ch,
	output b64dec_pkg::char_class_t            cls
);
	import b64dec_pkg::*;

	always_comb begin
		cls = classify(ch);
	end

endmodule

`default_nettype wire

@@ rtl/b64dec_accum.sv @@
// b64dec_accum: bit accumulator, byte counter and sticky error for the base64 decoder
// depends on b64dec_pkg; fed by b64dec_class
`timescale 1ns / 1ps
`default_nettype none

module b64dec_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire b64dec_pkg::char_class_t       cls,
	input  wire logic                          last,
	input  wire logic [b64dec_pkg::CountW-1:0] max_bytes,
	output logic                               has_result,
	output b64dec_pkg::result_t                res
);
	import b64dec_pkg::*;

	logic [SextW-1:0]  residue_q;
	logic [BitsW-1:0]  residue_bits_q;
	logic [CountW-1:0] produced_q;
	err_t              error_q;

	logic [SextW-1:0]   residue_d;
	logic [BitsW-1:0]   residue_bits_d;
	logic [CountW-1:0]  produced_d;
	err_t               error_d;
	logic [2*SextW-1:0] acc;
	logic [2*SextW-1:0] acc_shr;
	logic [BitsW-1:0]   keep;
	logic [SextW-1:0]   keep_mask;
	logic               emit;
	logic               raised;

	always_comb begin
		residue_d      = residue_q;
		residue_bits_d = residue_bits_q;
		produced_d     = produced_q;
		error_d        = error_q;
		emit           = 1'b0;
		raised         = 1'b0;
		acc            = {residue_q, cls.value};
		// eight of the 6+residue bits leave per byte, so the residue shrinks by two
		keep           = residue_bits_q - BitsW'(2);
		acc_shr        = acc >> keep;
		keep_mask      = (SextW'(1) << keep) - SextW'(1);

		if (error_q == ERR_NONE) begin
			unique case (cls.kind)
				CLS_INVALID: begin
					error_d = ERR_INVALID;
					raised  = 1'b1;
				end
				CLS_SEXTET: begin
					if (residue_bits_q != '0) begin
						if (produced_q >= max_bytes) begin
							error_d = ERR_OVERFLOW;
							raised  = 1'b1;
						end else begin
							emit           = 1'b1;
							produced_d     = produced_q + CountW'(1);
							residue_d      = acc[SextW-1:0] & keep_mask;
							residue_bits_d = keep;
						end
					end else begin
						residue_d      = cls.value;
						residue_bits_d = BitsW'(SextW);
					end
				end
				default: ;
			endcase
		end

		has_result     = emit || raised || last;
		res.data_byte  = emit ? acc_shr[CharW-1:0] : '0;
		res.byte_valid = emit;
		res.error_code = error_d;
		res.done_res   = last;
		res.byte_count = produced_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_q      <= '0;
			residue_bits_q <= '0;
			produced_q     <= '0;
			error_q        <= ERR_NONE;
		end else if (step_en) begin
			if (last) begin
				residue_q      <= '0;
				residue_bits_q <= '0;
				produced_q     <= '0;
				error_q        <= ERR_NONE;
			end else begin
				residue_q      <= residue_d;
				residue_bits_q <= residue_bits_d;
				produced_q     <= produced_d;
				error_q        <= error_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/base64_decoder.sv @@
// base64_decoder: top level of the streaming base64 decoder
// depends on b64dec_pkg, b64dec_class and b64dec_accum
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+-----------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: ch; tlast: last
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: byte, error, count;
//           |           |                             | tuser: byte_valid; tlast: done
// cfg       | in        | cfg_valid/cfg_ready         | cfg_data: max_bytes
//
// one character per clock unless the output stalls; input register to result register
// the rate is set by the accumulator update between the two registers
// a character giving no result leaves the pipe without touching the output register
// a stalled output holds back only a character that would need the output register
// reset clears the accumulator, byte count, error and valid flags; max_bytes returns to 32
// configuration writes are always taken (cfg_ready tied high)

module base64_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input characters
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // last
	// decoded results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] error_code,
	                                         // [17:10] byte_count, [23:18] zero
	output logic             m_axis_tuser,   // byte_valid
	output logic             m_axis_tlast,   // done_res
	// capacity register
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data       // max_bytes
);
	import b64dec_pkg::*;

	// input register stage
	logic             valid_s1;
	logic [CharW-1:0] ch_s1;
	logic             last_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;

	logic [CountW-1:0] max_bytes_q;

	char_class_t cls;
	logic        has_result;
	result_t     res;
	logic        out_free;
	logic        step_s1;
	logic        in_xfer;

	// output register can take a result this cycle
	assign out_free = !out_valid_q || m_axis_tready;
	// the held character retires unless it needs a busy output register
	assign step_s1  = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || step_s1;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	b64dec_class u_class (
		.ch  (ch_s1),
		.cls (cls)
	);

	b64dec_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_s1),
		.cls        (cls),
		.last       (last_s1),
		.max_bytes  (max_bytes_q),
		.has_result (has_result),
		.res        (res)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MaxBytesReset;
		end else if (cfg_valid && cfg_ready) begin
			max_bytes_q <= cfg_data;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step_s1 && has_result) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, res_q.byte_count, res_q.error_code, res_q.data_byte};
	assign m_axis_tuser  = res_q.byte_valid;
	assign m_axis_tlast  = res_q.done_res;

	// a decoded byte never travels together with an error
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[9:8] == ERR_NONE))
		else $error("byte reported together with an error");

	// a byte result always counts at least that byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[17:10] != '0))
		else $error("byte result with zero byte count");

	// a result that is neither a byte nor done must be an error report
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser && !m_axis_tlast) |->
		(m_axis_tdata[9:8] == ERR_INVALID || m_axis_tdata[9:8] == ERR_OVERFLOW))
		else $error("empty result emitted");

	// input is held off only behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench: self-checking bench for the streaming base64 decoder
// depends on b64dec_pkg and base64_decoder; predicts every result and checks it in order
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import b64dec_pkg::*;

	localparam int unsigned QuietLimit  = 2000;  // cycles with no transfer anywhere
	localparam int unsigned RandomChars = 1050;
	localparam int unsigned SettleTime  = 4;     // pipe is two deep, give it a little more

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// character stream into the decoder
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] ch
	logic        s_axis_tlast  = 1'b0; // last

	// decoded results out of the decoder
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [7:0] data_byte, [9:8] error_code, [17:10] byte_count
	logic        m_axis_tuser;         // byte_valid
	logic        m_axis_tlast;         // done_res

	// capacity register write channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;       // max_bytes

	base64_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// decoder state as the bench sees it, updated at each accepted character
	logic [7:0] dec_cap      = MaxBytesReset;
	logic [5:0] dec_residue  = '0;
	logic [2:0] dec_bits     = '0;
	logic [7:0] dec_produced = '0;
	err_t       dec_err      = ERR_NONE;

	result_t     pending_results[$];
	int unsigned fail_count  = 0;
	int unsigned chars_sent  = 0;
	bit          idle_on     = 1'b0;  // random gaps on both sides when set
	int unsigned quiet_cycles = 0;
	int unsigned rx_hold     = 0;
	int unsigned rx_gap;
	result_t     want;

	// mostly no gap, sometimes a short one, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// alphabet lookup: sextet value, skipped character or invalid
	function automatic void sort_char(input logic [7:0] c, output cls_kind_t kind,
	                                  output logic [5:0] sext);
		kind = CLS_SEXTET;
		sext = '0;
		if (c >= ChUpA && c <= ChUpZ) begin
			sext = UpperBase + 6'(c - ChUpA);
		end else if (c >= ChLoA && c <= ChLoZ) begin
			sext = LowerBase + 6'(c - ChLoA);
		end else if (c >= Ch0 && c <= Ch9) begin
			sext = DigitBase + 6'(c - Ch0);
		end else if (c == ChPlus) begin
			sext = PlusCode;
		end else if (c == ChSlash) begin
			sext = SlashCode;
		end else if (c == ChPad || c == ChLf || c == ChCr || c == ChSpace) begin
			kind = CLS_SKIP;
		end else begin
			kind = CLS_INVALID;
		end
	endfunction

	// sextet value back to its character, for building encoded text
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < LowerBase) begin
			return ChUpA + 8'(v);
		end else if (v < DigitBase) begin
			return ChLoA + 8'(v - LowerBase);
		end else if (v < PlusCode) begin
			return Ch0 + 8'(v - DigitBase);
		end else if (v == PlusCode) begin
			return ChPlus;
		end
		return ChSlash;
	endfunction

	function automatic logic [7:0] skip_char();
		case ($urandom_range(0, 3))
			0: begin
				return ChPad;
			end
			1: begin
				return ChLf;
			end
			2: begin
				return ChCr;
			end
			default: begin
				return ChSpace;
			end
		endcase
	endfunction

	// advance the decoder state by one character and queue the result it causes
	task automatic decode_char(input logic [7:0] c, input logic lst);
		cls_kind_t   kind;
		logic [5:0]  sext;
		logic [11:0] acc;
		logic [3:0]  total;
		logic [3:0]  keep;
		logic        emit;
		logic        raised;
		logic [7:0]  out_byte;
		result_t     r;
		emit     = 1'b0;
		raised   = 1'b0;
		out_byte = '0;
		// while an error is pending every character is ignored
		if (dec_err == ERR_NONE) begin
			sort_char(c, kind, sext);
			if (kind == CLS_INVALID) begin
				dec_err = ERR_INVALID;
				raised  = 1'b1;
			end else if (kind == CLS_SEXTET) begin
				acc   = {dec_residue, sext};
				total = {1'b0, dec_bits} + 4'd6;
				if (total >= 4'd8) begin
					keep = total - 4'd8;
					if (dec_produced >= dec_cap) begin
						// byte ready but no room left: dropped, overflow raised
						dec_err = ERR_OVERFLOW;
						raised  = 1'b1;
					end else begin
						out_byte     = 8'(acc >> keep);
						emit         = 1'b1;
						dec_produced = dec_produced + 8'd1;
						dec_residue  = 6'(acc & ((12'd1 << keep) - 12'd1));
						dec_bits     = keep[2:0];
					end
				end else begin
					dec_residue = acc[5:0];
					dec_bits    = total[2:0];
				end
			end
		end
		if (emit || raised || lst) begin
			r.data_byte  = out_byte;
			r.byte_valid = emit;
			r.error_code = dec_err;
			r.done_res   = lst;
			r.byte_count = dec_produced;
			pending_results.push_back(r);
		end
		// end of string: leftover bits are dropped, capacity stays
		if (lst) begin
			dec_residue  = '0;
			dec_bits     = '0;
			dec_produced = '0;
			dec_err      = ERR_NONE;
		end
	endtask

	// one character transfer, then an optional gap with valid low
	task automatic send_char(input logic [7:0] c, input logic lst);
		int unsigned g;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		decode_char(c, lst);
		chars_sent++;
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// hold the sender until every queued result has come back, then let the pipe settle
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleTime) @(posedge clk);
	endtask

	// capacity write, only while the decoder is idle
	task automatic set_capacity(input logic [7:0] cap);
		wait_for_results();
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		dec_cap = cap;
	endtask

	// one encoded string: alphabet chars with skips sprinkled in, optional noise
	// bytes, optional padding, last on the final character
	task automatic send_text(input int unsigned n, input bit noisy);
		int unsigned pads;
		int unsigned r;
		logic [7:0]  c;
		pads = noisy ? 0 : $urandom_range(0, 2);
		for (int unsigned i = 0; i < n + pads; i++) begin
			r = $urandom_range(0, 99);
			if (i >= n) begin
				c = ChPad;
			end else if (noisy && r < 5) begin
				c = 8'($urandom_range(0, 255));
			end else if (r < 12) begin
				c = skip_char();
			end else begin
				c = sextet_char(6'($urandom_range(0, 63)));
			end
			send_char(c, i == n + pads - 1);
		end
	endtask

	// alphabet extremes, skipped characters, sticky invalid, leftover bits
	task automatic test_directed();
		idle_on = 1'b0;
		// reset capacity of 32 is in force here
		send_char(ChUpA, 1'b0);
		send_char(ChSlash, 1'b0);
		send_char(ChLoZ, 1'b0);
		send_char(ChLoA, 1'b0);
		send_char(ChUpZ, 1'b0);
		send_char(Ch0, 1'b0);
		send_char(Ch9, 1'b0);
		send_char(ChPlus, 1'b0);
		// skipped characters, the last one still closes the string
		send_char(ChLf, 1'b0);
		send_char(ChCr, 1'b0);
		send_char(ChSpace, 1'b0);
		send_char(ChPad, 1'b1);
		// invalid character, then ignored ones until last
		send_char(8'h00, 1'b0);
		send_char(ChUpZ, 1'b0);
		send_char(8'hff, 1'b1);
		// last on a character that completes a byte
		send_char("Q", 1'b0);
		send_char("U", 1'b0);
		send_char("J", 1'b0);
		send_char("D", 1'b1);
		// three chars: the leftover two bits are dropped
		send_char("Q", 1'b0);
		send_char("Q", 1'b0);
		send_char("Q", 1'b1);
		// invalid character carrying last
		send_char(8'h80, 1'b1);
	endtask

	// zero, one and full capacity
	task automatic test_capacity();
		set_capacity(8'd0);
		send_char("T", 1'b0);
		send_char("Q", 1'b0);   // first byte ready overflows
		send_char(ChPad, 1'b0);
		send_char(ChPad, 1'b1);
		set_capacity(8'd1);
		send_text(8, 1'b0);     // one byte passes, the second overflows
		idle_on = 1'b1;
		set_capacity(8'd255);
		// 340 chars fill all 255 bytes, the next byte ready overflows
		for (int unsigned i = 0; i < 342; i++) begin
			send_char(sextet_char(6'($urandom_range(0, 63))), 1'b0);
		end
		send_char(ChUpA, 1'b1);
	endtask

	// random strings over phases of random capacity and idling
	task automatic test_random();
		int unsigned target;
		int unsigned phase;
		int unsigned r;
		int unsigned n;
		logic [7:0]  cap;
		target = chars_sent + RandomChars;
		phase  = 0;
		while (chars_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				cap = 8'd0;
			end else if (r < 20) begin
				cap = 8'd255;
			end else if (r < 40) begin
				cap = 8'($urandom_range(1, 4));
			end else begin
				cap = 8'($urandom_range(5, 48));
			end
			set_capacity(cap);
			// every third phase runs back to back with no gaps
			idle_on = (phase % 3) != 0;
			repeat (6) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					n = $urandom_range(1, 12);
				end else if (r < 95) begin
					n = $urandom_range(13, 40);
				end else begin
					n = $urandom_range(41, 80);
				end
				send_text(n, $urandom_range(0, 99) < 15);
				// sender stops now and then until the result side is empty
				if ($urandom_range(0, 99) < 3) begin
					wait_for_results();
				end
			end
			phase++;
		end
	endtask

	// result side: random back-pressure
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold       <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			rx_gap = gap_len();
			if (rx_gap != 0) begin
				rx_hold       <= rx_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string what, input logic [7:0] exp_val,
	                           input logic [7:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
			         $time, what, exp_val, act_val);
			fail_count++;
		end
	endtask

	// each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0h user %0b last %0b",
				         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
				check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser));
				check_field("error_code", 8'(want.error_code), 8'(m_axis_tdata[9:8]));
				check_field("done_res", 8'(want.done_res), 8'(m_axis_tlast));
				check_field("byte_count", want.byte_count, m_axis_tdata[17:10]);
			end
		end
	end

	// watchdog: too long with no transfer on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QuietLimit) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_random();
		wait_for_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ base64_decoder.f @@
rtl/b64dec_pkg.sv
rtl/b64dec_class.sv
rtl/b64dec_accum.sv
rtl/base64_decoder.sv
test/testbench.sv
